### sv/msws_pkg.sv
// ============================================================================
// msws_pkg
// Shared beat types, field widths and register codes for the maximum square
// window sum unit.
// ============================================================================
package msws_pkg;

    localparam int ELEM_W      = 16;
    localparam int SUM_W       = 25;
    localparam int ROW_CNT_W   = 11;
    localparam int COL_CNT_W   = 7;
    localparam int WIN_SIZE_W  = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd2;

    localparam logic [ROW_CNT_W-1:0]  ROW_COUNT_RST   = 11'd64;
    localparam logic [COL_CNT_W-1:0]  COL_COUNT_RST   = 7'd64;
    localparam logic [WIN_SIZE_W-1:0] WINDOW_SIZE_RST = 5'd3;

    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic                     last;
    } item_beat_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] max_sum;
        logic                    no_window;
    } result_beat_t;

endpackage

### sv/max_square_window_sum_unit.sv
// ============================================================================
// max_square_window_sum_unit
// Streams a signed matrix in raster order, builds 2D prefix sums in a ring
// memory and reports the largest window_size x window_size square sum.
// ----------------------------------------------------------------------------
// Channels: item (element, last) in, result (max_sum, no_window) out, both
// valid/ready; cfg writes row_count, col_count and window_size by index and
// is always ready. Write cfg only while the unit is idle.
// One beat per cycle while item_ready is high: each element does two reads and one
// write of the prefix ring (two read ports, one write port) in a single pass.
// A result beat is registered once the last-flagged item passes the final stage;
// only that beat is produced per matrix.
// Reset clears the frame state and loads the default registers; the ring
// needs no clearing pass, since every entry is written before it is read.
// When result_ready stays low with a result waiting, the unit keeps taking
// items until the next last-flagged item reaches the final stage, then holds
// item_ready low until the waiting result is taken.
// ============================================================================
module max_square_window_sum_unit #(
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_COLS   = 64,
    parameter int MAX_WINDOW = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  msws_pkg::item_beat_t              item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output msws_pkg::result_beat_t            result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [msws_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [msws_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import msws_pkg::*;

    localparam int RING_ROWS = MAX_WINDOW + 1;
    localparam int RR_W      = $clog2(RING_ROWS);
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CLIM_W    = $clog2(MAX_COLS + 1);
    localparam int ROW_W     = $clog2(MAX_ROWS + 1);
    localparam int TAP_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int PREFIX_W  = ELEM_W + $clog2(MAX_ROWS) + $clog2(MAX_COLS) + 2;
    localparam int SUMX_W    = PREFIX_W + 2;

    // configuration
    logic [ROW_CNT_W-1:0]  row_count_reg;
    logic [COL_CNT_W-1:0]  col_count_reg;
    logic [WIN_SIZE_W-1:0] window_size_reg;

    // frame position
    logic [ROW_W-1:0] row_idx_reg;
    logic [COL_W-1:0] col_idx_reg;
    logic [RR_W-1:0]  ring_row_reg;

    // stage 1
    logic                       s1_valid_reg;
    logic                       s1_last_reg;
    logic                       s1_active_reg;
    logic signed [ELEM_W-1:0]   s1_elem_reg;
    logic [RR_W-1:0]            s1_ring_row_reg;
    logic [COL_W-1:0]           s1_col_reg;
    logic                       s1_up_ok_reg;
    logic                       s1_win_reg;
    logic                       s1_top_ok_reg;
    logic                       s1_left_ok_reg;
    logic                       s1_eol_reg;
    logic [TAP_W-1:0]           s1_tap_reg;
    logic                       s1_fwd_up_reg;
    logic                       s1_fwd_top_reg;
    logic signed [PREFIX_W-1:0] s1_fwd_data_reg;
    logic signed [PREFIX_W-1:0] up_rd_reg;
    logic signed [PREFIX_W-1:0] top_rd_reg;
    logic signed [PREFIX_W-1:0] left_reg;
    logic signed [PREFIX_W-1:0] diag_reg;

    // stage 2
    logic                       s2_valid_reg;
    logic                       s2_last_reg;
    logic                       s2_win_reg;
    logic signed [PREFIX_W-1:0] s2_p_reg;
    logic signed [PREFIX_W-1:0] s2_a_reg;
    logic signed [PREFIX_W-1:0] s2_b_reg;
    logic signed [PREFIX_W-1:0] s2_c_reg;

    // stage 3
    logic                       s3_valid_reg;
    logic                       s3_last_reg;
    logic                       s3_win_reg;
    logic signed [SUMX_W-1:0]   s3_sum_reg;
    logic signed [SUM_W-1:0]    best_reg;
    logic                       found_reg;

    // result
    logic                       result_valid_reg;
    result_beat_t               result_reg;

    // storage
    logic signed [PREFIX_W-1:0] ring_mem [RING_ROWS][MAX_COLS];
    logic signed [PREFIX_W-1:0] cur_line_reg [MAX_WINDOW];
    logic signed [PREFIX_W-1:0] top_line_reg [MAX_WINDOW];

    // combinational
    logic                       adv;
    logic                       item_fire;
    logic [ROW_W-1:0]           rows_lim;
    logic [CLIM_W-1:0]          cols_lim;
    logic                       active;
    logic                       eol;
    logic                       k_ok;
    logic [WIN_SIZE_W-1:0]      k_eff;
    logic                       up_ok;
    logic                       top_ok;
    logic                       left_ok;
    logic                       win;
    logic [TAP_W-1:0]           tap;
    logic [RR_W-1:0]            up_row;
    logic [RR_W-1:0]            top_row;
    logic signed [31:0]         top_diff;
    logic                       s1_fire;
    logic signed [PREFIX_W-1:0] up_val;
    logic signed [PREFIX_W-1:0] top_val;
    logic signed [PREFIX_W-1:0] p_val;
    logic signed [SUMX_W-1:0]   sum_next;
    logic signed [SUM_W-1:0]    sat_val;
    logic signed [SUM_W-1:0]    best_next;
    logic                       found_next;

    assign cfg_ready    = 1'b1;
    assign adv          = !(s3_valid_reg && s3_last_reg && result_valid_reg && !result_ready);
    assign item_ready   = adv;
    assign item_fire    = item_valid && item_ready;
    assign s1_fire      = adv && s1_valid_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Address and flag setup at the input beat
    // ------------------------------------------------------------------
    always_comb
    begin
        if (row_count_reg == '0)
            rows_lim = ROW_W'(1);
        else if (32'(row_count_reg) > 32'(MAX_ROWS))
            rows_lim = ROW_W'(MAX_ROWS);
        else
            rows_lim = ROW_W'(row_count_reg);

        if (col_count_reg == '0)
            cols_lim = CLIM_W'(1);
        else if (32'(col_count_reg) > 32'(MAX_COLS))
            cols_lim = CLIM_W'(MAX_COLS);
        else
            cols_lim = CLIM_W'(col_count_reg);

        active  = row_idx_reg < rows_lim;
        eol     = (32'(col_idx_reg) + 32'd1) >= 32'(cols_lim);
        k_ok    = (window_size_reg != '0) && (32'(window_size_reg) <= 32'(MAX_WINDOW));
        k_eff   = k_ok ? window_size_reg : WIN_SIZE_W'(1);
        up_ok   = row_idx_reg != '0;
        top_ok  = 32'(row_idx_reg) >= 32'(k_eff);
        left_ok = 32'(col_idx_reg) >= 32'(k_eff);
        win     = k_ok && (32'(row_idx_reg) + 32'd1 >= 32'(k_eff))
                       && (32'(col_idx_reg) + 32'd1 >= 32'(k_eff));
        tap     = TAP_W'(k_eff - WIN_SIZE_W'(1));

        up_row   = (ring_row_reg == '0) ? RR_W'(RING_ROWS - 1) : ring_row_reg - RR_W'(1);
        top_diff = $signed(32'(ring_row_reg)) - $signed(32'(k_eff));
        if (top_diff < 0)
            top_row = RR_W'(top_diff + RING_ROWS);
        else
            top_row = RR_W'(top_diff);
    end

    // ------------------------------------------------------------------
    // Stage 1: prefix sum and window corners
    // ------------------------------------------------------------------
    always_comb
    begin
        if (!s1_up_ok_reg)
            up_val = '0;
        else if (s1_fwd_up_reg)
            up_val = s1_fwd_data_reg;
        else
            up_val = up_rd_reg;

        top_val = s1_fwd_top_reg ? s1_fwd_data_reg : top_rd_reg;
        p_val   = left_reg + up_val - diag_reg + PREFIX_W'(s1_elem_reg);
    end

    // ------------------------------------------------------------------
    // Stage 2 and 3: window sum, clamp, running maximum
    // ------------------------------------------------------------------
    always_comb
    begin
        sum_next = SUMX_W'(s2_p_reg) - SUMX_W'(s2_a_reg) - SUMX_W'(s2_b_reg)
                   + SUMX_W'(s2_c_reg);

        if (s3_sum_reg < SUMX_W'(SUM_MIN))
            sat_val = SUM_MIN;
        else if (s3_sum_reg > SUMX_W'(SUM_MAX))
            sat_val = SUM_MAX;
        else
            sat_val = s3_sum_reg[SUM_W-1:0];

        best_next  = best_reg;
        found_next = found_reg;
        if (s3_win_reg)
        begin
            if (!found_reg || (sat_val > best_reg))
                best_next = sat_val;
            found_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Prefix ring memory
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_active_reg)
            ring_mem[s1_ring_row_reg][s1_col_reg] <= p_val;
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            up_rd_reg  <= ring_mem[up_row][col_idx_reg];
            top_rd_reg <= ring_mem[top_row][col_idx_reg];
        end
    end

    // ------------------------------------------------------------------
    // Row-local delay lines for the left corners
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_active_reg)
        begin
            cur_line_reg[0] <= p_val;
            top_line_reg[0] <= top_val;
            for (int n = 1; n < MAX_WINDOW; n++)
            begin
                cur_line_reg[n] <= cur_line_reg[n-1];
                top_line_reg[n] <= top_line_reg[n-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_elem_reg      <= item.element;
            s1_ring_row_reg  <= ring_row_reg;
            s1_col_reg       <= col_idx_reg;
            s1_up_ok_reg     <= up_ok;
            s1_win_reg       <= win;
            s1_top_ok_reg    <= top_ok;
            s1_left_ok_reg   <= left_ok;
            s1_eol_reg       <= eol;
            s1_tap_reg       <= tap;
            s1_fwd_data_reg  <= p_val;
        end
        if (s1_fire)
        begin
            s2_p_reg <= p_val;
            s2_a_reg <= s1_top_ok_reg ? top_val : '0;
            s2_b_reg <= s1_left_ok_reg ? cur_line_reg[s1_tap_reg] : '0;
            s2_c_reg <= (s1_top_ok_reg && s1_left_ok_reg) ? top_line_reg[s1_tap_reg] : '0;
        end
        if (adv && s2_valid_reg)
            s3_sum_reg <= sum_next;
        if (adv && s3_valid_reg && s3_last_reg)
        begin
            result_reg.max_sum   <= found_next ? best_next : '0;
            result_reg.no_window <= !found_next;
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= ROW_COUNT_RST;
            col_count_reg    <= COL_COUNT_RST;
            window_size_reg  <= WINDOW_SIZE_RST;
            row_idx_reg      <= '0;
            col_idx_reg      <= '0;
            ring_row_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            s1_last_reg      <= 1'b0;
            s1_active_reg    <= 1'b0;
            s1_fwd_up_reg    <= 1'b0;
            s1_fwd_top_reg   <= 1'b0;
            left_reg         <= '0;
            diag_reg         <= '0;
            s2_valid_reg     <= 1'b0;
            s2_last_reg      <= 1'b0;
            s2_win_reg       <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s3_last_reg      <= 1'b0;
            s3_win_reg       <= 1'b0;
            best_reg         <= SUM_MIN;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROW_COUNT:   row_count_reg   <= cfg_data[ROW_CNT_W-1:0];
                    CFG_COL_COUNT:   col_count_reg   <= cfg_data[COL_CNT_W-1:0];
                    CFG_WINDOW_SIZE: window_size_reg <= cfg_data[WIN_SIZE_W-1:0];
                    default:         ;
                endcase
            end

            // advance the frame position per input beat
            if (item_fire)
            begin
                if (item.last)
                begin
                    row_idx_reg  <= '0;
                    col_idx_reg  <= '0;
                    ring_row_reg <= '0;
                end
                else if (active)
                begin
                    if (eol)
                    begin
                        col_idx_reg <= '0;
                        row_idx_reg <= row_idx_reg + ROW_W'(1);
                        if (32'(ring_row_reg) == RING_ROWS - 1)
                            ring_row_reg <= '0;
                        else
                            ring_row_reg <= ring_row_reg + RR_W'(1);
                    end
                    else
                        col_idx_reg <= col_idx_reg + COL_W'(1);
                end
            end

            if (adv)
            begin
                s1_valid_reg <= item_fire;
                if (item_fire)
                begin
                    s1_last_reg    <= item.last;
                    s1_active_reg  <= active;
                    s1_fwd_up_reg  <= s1_valid_reg && s1_active_reg
                                      && (s1_ring_row_reg == up_row)
                                      && (s1_col_reg == col_idx_reg);
                    s1_fwd_top_reg <= s1_valid_reg && s1_active_reg
                                      && (s1_ring_row_reg == top_row)
                                      && (s1_col_reg == col_idx_reg);
                end

                s2_valid_reg <= s1_valid_reg;
                s2_last_reg  <= s1_last_reg;
                s2_win_reg   <= s1_valid_reg && s1_active_reg && s1_win_reg;

                s3_valid_reg <= s2_valid_reg;
                s3_last_reg  <= s2_last_reg;
                s3_win_reg   <= s2_valid_reg && s2_win_reg;
            end

            // hold left and diagonal prefixes across the row
            if (s1_fire)
            begin
                if (s1_last_reg || (s1_active_reg && s1_eol_reg))
                begin
                    left_reg <= '0;
                    diag_reg <= '0;
                end
                else if (s1_active_reg)
                begin
                    left_reg <= p_val;
                    diag_reg <= up_val;
                end
            end

            if (adv && s3_valid_reg)
            begin
                if (s3_last_reg)
                begin
                    best_reg  <= SUM_MIN;
                    found_reg <= 1'b0;
                end
                else
                begin
                    best_reg  <= best_next;
                    found_reg <= found_next;
                end
            end

            if (adv && s3_valid_reg && s3_last_reg)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

endmodule
